/* design/sdf_pkg.sv */
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the signed decimal formatter
// Character codes, field widths, the digit sequencer states, the result
// record and the power-of-ten table used by the digit stage.
// ----------------------------------------------------------------------------
package sdf_pkg;

    // default integer width, fixed result field widths and other sizes
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CHAR_WIDTH      = 8;
    localparam int COUNT_WIDTH     = 4;
    localparam int POW_WIDTH       = 68;
    localparam int POW_INDEX_WIDTH = 5;
    localparam int MAX_DIGIT       = 9;
    localparam int QUEUE_DEPTH     = 2;

    // ascii codes
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

    // digit sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } back_state_t;

    // one result item
    typedef struct packed {
        logic [CHAR_WIDTH-1:0]  ch;
        logic                   last;
        logic [COUNT_WIDTH-1:0] count;
    } sdf_result_t;

    // decimal digits needed for the largest magnitude, 2^(w-1)
    function automatic int digits_for(input int w);
        logic [63:0] v;
        int          n;
        v = 64'd1 << (w - 1);
        n = 0;
        while (v != 64'd0)
        begin
            v = v / 64'd10;
            n = n + 1;
        end
        return n;
    endfunction

    // ten to the power k, k up to nineteen
    function automatic logic [POW_WIDTH-1:0] pow10(input logic [POW_INDEX_WIDTH-1:0] k);
        logic [POW_WIDTH-1:0] p;
        case (k)
            5'd0:    p = 68'd1;
            5'd1:    p = 68'd10;
            5'd2:    p = 68'd100;
            5'd3:    p = 68'd1000;
            5'd4:    p = 68'd10000;
            5'd5:    p = 68'd100000;
            5'd6:    p = 68'd1000000;
            5'd7:    p = 68'd10000000;
            5'd8:    p = 68'd100000000;
            5'd9:    p = 68'd1000000000;
            5'd10:   p = 68'd10000000000;
            5'd11:   p = 68'd100000000000;
            5'd12:   p = 68'd1000000000000;
            5'd13:   p = 68'd10000000000000;
            5'd14:   p = 68'd100000000000000;
            5'd15:   p = 68'd1000000000000000;
            5'd16:   p = 68'd10000000000000000;
            5'd17:   p = 68'd100000000000000000;
            5'd18:   p = 68'd1000000000000000000;
            5'd19:   p = 68'd10000000000000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

/* design/signed_decimal_formatter.sv */
// ----------------------------------------------------------------------------
// signed_decimal_formatter: signed integer to decimal ascii text
// Usage:
//   Input side: drive value and raise push; the item is taken at a clock edge
//   where push is high and full is low. A two-entry queue holds items waiting
//   for the digit sequencer, so up to two items may be pushed ahead.
//   Result side: while empty is low, char_out, last and char_count show the
//   oldest character; pop takes it. One character per item of text: a '-'
//   for negative values, then digits most significant first, no leading
//   zeros, zero as a single '0'. last marks the final character, which also
//   carries the character count (1 to 11 at 32 bits); other characters show
//   a count of zero.
//   Sequence: the sequencer takes an item, then handles the sign when negative
//   and then each possible digit position (10 at 32 bits) in turn; the first
//   character of a positive value is held back while its leading zero
//   positions are skipped.
//   A stalled receiver holds the result register; the sequencer waits and the
//   queue fills, then full rises. Reset empties the queue and result register.
// ----------------------------------------------------------------------------
module signed_decimal_formatter #(
    parameter int VALUE_WIDTH = sdf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [VALUE_WIDTH-1:0]        value,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [sdf_pkg::CHAR_WIDTH-1:0]       char_out,
    output logic                                 last,
    output logic [sdf_pkg::COUNT_WIDTH-1:0]      char_count
);
    import sdf_pkg::*;

    logic [VALUE_WIDTH:0] front_entry;
    logic [VALUE_WIDTH:0] q_data;
    logic                 q_valid;
    logic                 q_pop;
    logic                 res_valid;
    sdf_result_t          res;

    // sign and magnitude split
    sdf_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .value(value),
        .entry(front_entry)
    );

    // item queue
    sdf_queue #(
        .WIDTH(VALUE_WIDTH + 1)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (front_entry),
        .full (full),
        .pop  (q_pop),
        .valid(q_valid),
        .dout (q_data)
    );

    // digit sequencer and result register
    sdf_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .res_valid(res_valid),
        .res      (res),
        .res_pop  (pop)
    );

    // result ports
    assign empty      = !res_valid;
    assign char_out   = res.ch;
    assign last       = res.last;
    assign char_count = res.count;

endmodule

/* design/sdf_front.sv */
// ----------------------------------------------------------------------------
// sdf_front: input classifier
// Splits each incoming integer into a sign flag and an unsigned magnitude,
// so the most negative value keeps its full magnitude.
// ----------------------------------------------------------------------------
module sdf_front #(
    parameter int VALUE_WIDTH = sdf_pkg::VALUE_WIDTH_DEF
) (
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic        [VALUE_WIDTH:0]   entry
);
    import sdf_pkg::*;

    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;

    // sign and unsigned magnitude
    always_comb
    begin
        neg = value[VALUE_WIDTH-1];
        if (neg)
        begin
            mag = (~value) + VALUE_WIDTH'(1);
        end
        else
        begin
            mag = value;
        end
        entry = {neg, mag};
    end

endmodule

/* design/sdf_queue.sv */
// ----------------------------------------------------------------------------
// sdf_queue: short item queue between classifier and digit sequencer
// Two-entry first-in first-out store of classified items.
// ----------------------------------------------------------------------------
module sdf_queue #(
    parameter int WIDTH = sdf_pkg::VALUE_WIDTH_DEF + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] dout
);
    import sdf_pkg::*;

    localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]     store_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full    = (count_reg == CNT_WIDTH'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign dout    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PTR_WIDTH'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + PTR_WIDTH'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CNT_WIDTH'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_WIDTH'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* design/sdf_back.sv */
// ----------------------------------------------------------------------------
// sdf_back: digit sequencer and result register, one classified item at a time
// Emits the sign if negative, then finds one decimal digit per cycle while the
// result slot is free, from the top power of ten down, dropping leading zeros.
// ----------------------------------------------------------------------------
module sdf_back #(
    parameter int VALUE_WIDTH = sdf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  logic [VALUE_WIDTH:0]       q_data,
    output logic                       q_pop,
    output logic                       res_valid,
    output sdf_pkg::sdf_result_t       res,
    input  logic                       res_pop
);
    import sdf_pkg::*;

    localparam int DIGITS = digits_for(VALUE_WIDTH);
    localparam int KW     = $clog2(DIGITS);

    back_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [KW-1:0]          k_reg, k_next;
    logic                   started_reg, started_next;
    logic [COUNT_WIDTH-1:0] emit_index_reg, emit_index_next;
    sdf_result_t            res_reg;
    logic                   res_valid_reg;

    logic                   slot_free;
    logic                   load;
    logic                   emit;
    logic                   step;
    logic                   is_lead;
    sdf_result_t            emit_res;
    logic [POW_WIDTH-1:0]   mag_ext;
    logic [POW_WIDTH:0]     diff    [MAX_DIGIT+1];
    logic [3:0]             digit;
    logic [VALUE_WIDTH-1:0] rem;

    assign slot_free = !res_valid_reg || res_pop;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign mag_ext   = POW_WIDTH'(mag_reg);

    // trial subtraction of every multiple of the current power of ten
    always_comb
    begin
        for (int j = 0; j <= MAX_DIGIT; j++)
        begin
            diff[j] = {1'b0, mag_ext}
                    - {1'b0, pow10(POW_INDEX_WIDTH'(k_reg)) * POW_WIDTH'(j)};
        end
    end

    // largest multiple that fits gives the digit and the remainder
    always_comb
    begin
        digit = '0;
        rem   = mag_reg;
        for (int j = 1; j <= MAX_DIGIT; j++)
        begin
            if (!diff[j][POW_WIDTH])
            begin
                digit = 4'(j);
                rem   = diff[j][VALUE_WIDTH-1:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                    state_next = q_data[VALUE_WIDTH] ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (slot_free)
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (step && (k_reg == '0))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        load          = 1'b0;
        emit          = 1'b0;
        step          = 1'b0;
        is_lead       = 1'b0;
        emit_res.ch    = CHAR_ZERO + CHAR_WIDTH'(digit);
        emit_res.last  = 1'b0;
        emit_res.count = '0;
        case (state_reg)
            ST_IDLE:
            begin
                load = q_valid;
            end
            ST_SIGN:
            begin
                emit        = slot_free;
                emit_res.ch = CHAR_MINUS;
            end
            ST_DIGIT:
            begin
                is_lead = (digit == '0) && !started_reg && (k_reg != '0);
                step    = is_lead || slot_free;
                emit    = !is_lead && slot_free;
                if (k_reg == '0)
                begin
                    emit_res.last  = 1'b1;
                    emit_res.count = emit_index_reg + COUNT_WIDTH'(1);
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign q_pop = load;

    // working register next values
    always_comb
    begin
        mag_next        = mag_reg;
        k_next          = k_reg;
        started_next    = started_reg;
        emit_index_next = emit_index_reg;
        if (load)
        begin
            mag_next        = q_data[VALUE_WIDTH-1:0];
            k_next          = KW'(DIGITS - 1);
            started_next    = 1'b0;
            emit_index_next = '0;
        end
        else
        begin
            if (emit)
                emit_index_next = emit_index_reg + COUNT_WIDTH'(1);
            if (step)
            begin
                mag_next = rem;
                if (!is_lead)
                    started_next = 1'b1;
                if (k_reg != '0)
                    k_next = k_reg - KW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            started_reg    <= 1'b0;
            emit_index_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            started_reg    <= started_next;
            emit_index_reg <= emit_index_next;
            if (emit)
                res_valid_reg <= 1'b1;
            else if (res_pop)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (emit)
            res_reg <= emit_res;
    end

`ifndef NO_ASSERTIONS
    // an item is only taken when the sequencer is free and one is waiting
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE) && q_valid)
        else $error("item taken while sequencer busy");

    // a waiting result that is not the last one carries a zero count
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.last |-> res_reg.count == '0)
        else $error("non-final character with nonzero count");

    // the first digit written is never a leading zero unless it is the only one
    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        emit && (state_reg == ST_DIGIT) && !started_reg |-> (digit != '0) || (k_reg == '0))
        else $error("leading zero emitted");

    // the final character returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_res.last |=> state_reg == ST_IDLE)
        else $error("sequencer busy after final character");

    // a result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !res_valid_reg || res_pop)
        else $error("waiting result overwritten");
`endif

endmodule
